### rtl/pbba_pkg.sv
// Package for the point bearing block: widths, sector type, stage payloads
// and the CORDIC arctangent table. No dependencies.
package pbba_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 18;

  localparam int TABLE_LEN = 30;
  localparam int PRESHIFT  = 60 - COORD_WIDTH;
  // difference width, magnitude width after preshift, CORDIC datapath width
  localparam int DW   = COORD_WIDTH + 1;
  localparam int MAGW = DW + PRESHIFT;
  localparam int XYW  = MAGW + 3;
  // angle accumulator and turn word (2^32 units per turn)
  localparam int ZW  = 32;
  localparam int TW  = 32;
  localparam int QW  = TW - 2;

  localparam logic signed [ZW-1:0] Z_MIN = ZW'(1);
  localparam logic signed [ZW-1:0] Z_MAX = ZW'((64'd1 << QW) - 64'd1);

  typedef enum logic [1:0] {
    QTR_EAST  = 2'd0,
    QTR_NORTH = 2'd1,
    QTR_WEST  = 2'd2,
    QTR_SOUTH = 2'd3
  } quarter_t;

  typedef struct packed {
    logic     axis;
    logic     sub;
    quarter_t quarter;
  } sector_t;

  typedef struct packed {
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } diff_t;

  typedef struct packed {
    logic signed [XYW-1:0] x;
    logic signed [XYW-1:0] y;
    logic signed [ZW-1:0]  z;
    sector_t               sec;
  } cdc_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [ZW-1:0] ATAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

endpackage

### rtl/pbba_in_if.sv
// Input channel: one pair of points per transfer, valid/ready handshake.
// Depends on pbba_pkg.
interface pbba_in_if;
  import pbba_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] from_x;
  logic signed [COORD_WIDTH-1:0] from_y;
  logic signed [COORD_WIDTH-1:0] to_x;
  logic signed [COORD_WIDTH-1:0] to_y;

  modport source (output valid, from_x, from_y, to_x, to_y, input ready);
  modport sink   (input valid, from_x, from_y, to_x, to_y, output ready);
endinterface

### rtl/pbba_out_if.sv
// Output channel: one bearing per transfer, valid/ready handshake.
// Depends on pbba_pkg.
interface pbba_out_if;
  import pbba_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] bearing;

  modport source (output valid, bearing, input ready);
  modport sink   (input valid, bearing, output ready);
endinterface

### rtl/pbba_fold.sv
// Two front stages: coordinate differences, then quadrant fold into CORDIC
// start vectors. Depends on pbba_pkg.
module pbba_fold (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic signed [pbba_pkg::COORD_WIDTH-1:0] from_x,
  input  logic signed [pbba_pkg::COORD_WIDTH-1:0] from_y,
  input  logic signed [pbba_pkg::COORD_WIDTH-1:0] to_x,
  input  logic signed [pbba_pkg::COORD_WIDTH-1:0] to_y,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output pbba_pkg::cdc_t                         dn_data
);
  import pbba_pkg::*;

  logic    diff_vld;
  diff_t   diff;
  logic    diff_en;
  logic    fold_en;
  diff_t   diff_next;
  cdc_t    fold_next;
  logic    dx_zero, dy_zero, dx_neg, dy_neg;
  logic [DW-1:0] adx, ady, num, den;

  assign diff_en  = !diff_vld || fold_en;
  assign fold_en  = !dn_valid || dn_ready;
  assign up_ready = diff_en;

  always_comb begin
    diff_next.dx = $signed({to_x[COORD_WIDTH-1], to_x})
                 - $signed({from_x[COORD_WIDTH-1], from_x});
    diff_next.dy = $signed({to_y[COORD_WIDTH-1], to_y})
                 - $signed({from_y[COORD_WIDTH-1], from_y});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_vld <= 1'b0;
    end else if (diff_en) begin
      diff_vld <= up_valid;
    end
    if (diff_en && up_valid) begin
      diff <= diff_next;
    end
  end

  // fold the difference vector into an acute angle and its sector
  always_comb begin
    dx_zero = (diff.dx == '0);
    dy_zero = (diff.dy == '0);
    dx_neg  = diff.dx[DW-1];
    dy_neg  = diff.dy[DW-1];
    adx     = dx_neg ? DW'(-diff.dx) : DW'(diff.dx);
    ady     = dy_neg ? DW'(-diff.dy) : DW'(diff.dy);
    num     = ady;
    den     = adx;
    fold_next.sec.axis    = 1'b0;
    fold_next.sec.sub     = 1'b0;
    fold_next.sec.quarter = QTR_EAST;
    priority if (dx_zero && dy_zero) begin
      fold_next.sec.axis = 1'b1;
    end else if (dy_zero) begin
      fold_next.sec.axis    = 1'b1;
      fold_next.sec.quarter = dx_neg ? QTR_WEST : QTR_EAST;
    end else if (dx_zero) begin
      fold_next.sec.axis    = 1'b1;
      fold_next.sec.quarter = dy_neg ? QTR_SOUTH : QTR_NORTH;
    end else if (!dx_neg && !dy_neg) begin
      fold_next.sec.quarter = QTR_EAST;
    end else if (dx_neg && !dy_neg) begin
      fold_next.sec.sub     = 1'b1;
      fold_next.sec.quarter = QTR_WEST;
    end else if (dx_neg) begin
      num = adx;
      den = ady;
      fold_next.sec.sub     = 1'b1;
      fold_next.sec.quarter = QTR_SOUTH;
    end else begin
      fold_next.sec.sub     = 1'b1;
      fold_next.sec.quarter = QTR_EAST;
    end
    fold_next.x = $signed(XYW'({den, {PRESHIFT{1'b0}}}));
    fold_next.y = $signed(XYW'({num, {PRESHIFT{1'b0}}}));
    fold_next.z = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (fold_en) begin
      dn_valid <= diff_vld;
    end
    if (fold_en && diff_vld) begin
      dn_data <= fold_next;
    end
  end

endmodule

### rtl/pbba_cordic.sv
// Unrolled vectoring CORDIC, one register stage per iteration, with a
// per-stage valid and a backward ready chain. Depends on pbba_pkg.
module pbba_cordic (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  pbba_pkg::cdc_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output pbba_pkg::cdc_t dn_data
);
  import pbba_pkg::*;

  logic vld [CORDIC_STEPS+1];
  logic rdy [CORDIC_STEPS+1];
  cdc_t st  [CORDIC_STEPS+1];

  assign vld[0]             = up_valid;
  assign st[0]              = up_data;
  assign up_ready           = rdy[0];
  assign rdy[CORDIC_STEPS]  = dn_ready;
  assign dn_valid           = vld[CORDIC_STEPS];
  assign dn_data            = st[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cdc_t                  nxt;
    logic signed [XYW-1:0] xs, ys;
    logic                  pos;

    assign rdy[i] = !vld[i+1] || rdy[i+1];

    // rotate towards the x axis; y sign steers the rotation
    always_comb begin
      xs  = st[i].x >>> i;
      ys  = st[i].y >>> i;
      pos = !st[i].y[XYW-1] && (st[i].y != '0);
      nxt.sec = st[i].sec;
      if (pos) begin
        nxt.x = st[i].x + ys;
        nxt.y = st[i].y - xs;
        nxt.z = st[i].z + $signed(ATAB[i]);
      end else begin
        nxt.x = st[i].x - ys;
        nxt.y = st[i].y + xs;
        nxt.z = st[i].z - $signed(ATAB[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (rdy[i]) begin
        vld[i+1] <= vld[i];
      end
      if (rdy[i] && vld[i]) begin
        st[i+1] <= nxt;
      end
    end
  end

endmodule

### rtl/pbba_place.sv
// Final stage: clamp the acute angle, place it in its sector and hold the
// bearing in the output register. Depends on pbba_pkg.
module pbba_place (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  pbba_pkg::cdc_t                  up_data,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic [pbba_pkg::ANGLE_BITS-1:0] dn_bearing
);
  import pbba_pkg::*;

  logic          en;
  logic [QW-1:0] zc;
  logic [TW-1:0] base;
  logic [TW-1:0] turn;
  logic [1:0]    exp_q;

  assign en       = !dn_valid || dn_ready;
  assign up_ready = en;

  always_comb begin
    priority if (up_data.z < Z_MIN) begin
      zc = QW'(Z_MIN);
    end else if (up_data.z > Z_MAX) begin
      zc = QW'(Z_MAX);
    end else begin
      zc = up_data.z[QW-1:0];
    end
    base = {up_data.sec.quarter, {QW{1'b0}}};
    priority if (up_data.sec.axis) begin
      turn = base;
    end else if (up_data.sec.sub) begin
      turn = base - {2'b00, zc};
    end else begin
      turn = base + {2'b00, zc};
    end
    exp_q = up_data.sec.sub ? 2'(up_data.sec.quarter - 2'd1) : up_data.sec.quarter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (en) begin
      dn_valid <= up_valid;
    end
    if (en && up_valid) begin
      dn_bearing <= turn[TW-1 -: ANGLE_BITS];
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !dn_valid)
    else $error("output register not empty after reset");

  a_axis_exact: assert property (@(posedge clk) disable iff (rst)
    (en && up_valid && up_data.sec.axis) |=>
      (dn_bearing == {$past(up_data.sec.quarter), {(ANGLE_BITS-2){1'b0}}}))
    else $error("axis bearing not an exact quarter");

  a_in_quadrant: assert property (@(posedge clk) disable iff (rst)
    (en && up_valid && !up_data.sec.axis) |=>
      (dn_bearing[ANGLE_BITS-1 -: 2] == $past(exp_q)))
    else $error("bearing left its quadrant");

endmodule

### rtl/point_bearing_binary_angle_top.sv
// Point bearing top level: 21 register stages (difference, fold, 18 CORDIC,
// placement/output). Throughput one pair per cycle; a stage holds its item
// only while the next is full and stalled.
// Reset (rst, synchronous) empties every stage; payload registers keep old data.
// Depends on pbba_pkg, pbba_in_if, pbba_out_if, pbba_fold, pbba_cordic, pbba_place.
module point_bearing_binary_angle_top (
  input  logic       clk,
  input  logic       rst,
  pbba_in_if.sink    points,
  pbba_out_if.source result
);
  import pbba_pkg::*;

  // front end to CORDIC
  logic fold_valid;
  logic fold_ready;
  cdc_t fold_data;

  // CORDIC to placement
  logic rot_valid;
  logic rot_ready;
  cdc_t rot_data;

  // form dx, dy and fold them into the first quadrant
  pbba_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .up_valid (points.valid),
    .up_ready (points.ready),
    .from_x   (points.from_x),
    .from_y   (points.from_y),
    .to_x     (points.to_x),
    .to_y     (points.to_y),
    .dn_valid (fold_valid),
    .dn_ready (fold_ready),
    .dn_data  (fold_data)
  );

  // advance through the rotation stages, one iteration per register
  pbba_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fold_valid),
    .up_ready (fold_ready),
    .up_data  (fold_data),
    .dn_valid (rot_valid),
    .dn_ready (rot_ready),
    .dn_data  (rot_data)
  );

  // clamp, place into the sector and hold for the output transfer
  pbba_place u_place (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (rot_valid),
    .up_ready   (rot_ready),
    .up_data    (rot_data),
    .dn_valid   (result.valid),
    .dn_ready   (result.ready),
    .dn_bearing (result.bearing)
  );

endmodule

### tb/testbench.sv
// Self-checking bench for point_bearing_binary_angle_top: drives point pairs,
// predicts each bearing with a bit-exact CORDIC model and checks every result.
// Depends on pbba_pkg, pbba_in_if, pbba_out_if and the top level RTL.
module testbench;
  import pbba_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [ANGLE_BITS-1:0] bearing_t;

  // one outstanding pair and the bearing it must produce
  typedef struct {
    coord_t   from_x;
    coord_t   from_y;
    coord_t   to_x;
    coord_t   to_y;
    bearing_t bearing;
  } bearing_exp_t;

  localparam coord_t COORD_MIN    = coord_t'(32'h8000_0000);
  localparam coord_t COORD_MAX    = coord_t'(32'h7fff_ffff);
  localparam longint QUARTER_TURN = longint'(1) << QW;
  localparam int     PIPE_LATENCY = 21;
  localparam int     STALL_LIMIT  = 4000;
  localparam int     HOLD_CYCLES  = 160;
  localparam int     RANDOM_ITEMS = 370;

  logic clk = 1'b0;
  logic rst;

  pbba_in_if  points ();
  pbba_out_if result ();

  point_bearing_binary_angle_top u_top (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .result (result)
  );

  // 8 time unit period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  bearing_exp_t pending_bearings[$];
  int           pairs_sent;
  int           bearings_checked;
  int           mismatches;
  int           send_idle_pct;
  int           recv_stall_pct;
  logic         hold_off;

  // Acute angle atan(num/den) in 2^32-per-turn units, by a vectoring CORDIC
  // of CORDIC_STEPS stages; clamped so the answer stays inside its quadrant.
  function automatic longint acute_angle(input longint num, input longint den);
    longint x, y, z, xs, ys;
    int     i;
    x = den <<< PRESHIFT;
    y = num <<< PRESHIFT;
    z = 0;
    for (i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(ATAB[i]);
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(ATAB[i]);
      end
    end
    if (z < 1) z = 1;
    if (z > QUARTER_TURN - 1) z = QUARTER_TURN - 1;
    return z;
  endfunction

  // Bearing from the first point to the second, 2^ANGLE_BITS units per turn.
  function automatic bearing_t bearing_of(input coord_t fx, input coord_t fy,
                                          input coord_t tx, input coord_t ty);
    longint   dx, dy, num, den, turn;
    quarter_t qtr;
    dx = longint'(tx) - longint'(fx);
    dy = longint'(ty) - longint'(fy);
    if (dx == 0 && dy == 0) begin
      turn = 0;
    end else if (dy == 0) begin
      turn = (dx > 0) ? 0 : 2 * QUARTER_TURN;
    end else if (dx == 0) begin
      turn = (dy > 0) ? QUARTER_TURN : 3 * QUARTER_TURN;
    end else begin
      // fold the difference into an acute angle and note its quadrant
      if (dx > 0 && dy > 0) begin
        qtr = QTR_EAST;  num = dy;  den = dx;
      end else if (dx < 0 && dy > 0) begin
        qtr = QTR_NORTH; num = dy;  den = -dx;
      end else if (dx < 0) begin
        qtr = QTR_WEST;  num = -dx; den = -dy;
      end else begin
        qtr = QTR_SOUTH; num = -dy; den = dx;
      end
      case (qtr)
        QTR_EAST:  turn = acute_angle(num, den);
        QTR_NORTH: turn = 2 * QUARTER_TURN - acute_angle(num, den);
        QTR_WEST:  turn = 3 * QUARTER_TURN - acute_angle(num, den);
        default:   turn = 4 * QUARTER_TURN - acute_angle(num, den);
      endcase
    end
    return turn[TW-1 -: ANGLE_BITS];
  endfunction

  // Offer one pair after a random idle gap and hold it until the transfer.
  // Valid is only lowered when an idle cycle starts, so back-to-back pairs
  // keep it high without a drop in the same time step.
  task automatic send_pair(input coord_t fx, input coord_t fy,
                           input coord_t tx, input coord_t ty);
    while ($urandom_range(99) < send_idle_pct) begin
      points.valid <= 1'b0;
      @(posedge clk);
    end
    points.valid  <= 1'b1;
    points.from_x <= fx;
    points.from_y <= fy;
    points.to_x   <= tx;
    points.to_y   <= ty;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
    pairs_sent++;
  endtask

  // Random pair drawn from a mix: full-range noise, short hops, axis-aligned,
  // coincident and near-edge sweeps across the whole coordinate range.
  task automatic send_random_pair();
    coord_t fx, fy, tx, ty, lo, hi, d;
    int     pick;
    pick = $urandom_range(99);
    fx = coord_t'($urandom);
    fy = coord_t'($urandom);
    tx = coord_t'($urandom);
    ty = coord_t'($urandom);
    if (pick < 40) begin
      // full-range coordinates as drawn
    end else if (pick < 65) begin
      tx = fx + coord_t'(int'($urandom_range(2000)) - 1000);
      ty = fy + coord_t'(int'($urandom_range(2000)) - 1000);
    end else if (pick < 75) begin
      if ($urandom_range(1)) tx = fx;
      else ty = fy;
    end else if (pick < 83) begin
      tx = fx;
      ty = fy;
    end else begin
      lo = coord_t'(32'h8000_0000 + $urandom_range(255));
      hi = coord_t'(32'h7fff_ffff - $urandom_range(255));
      d  = coord_t'(int'($urandom_range(6)) - 3);
      if ($urandom_range(1)) begin
        fx = lo;
        tx = hi;
      end else begin
        fx = hi;
        tx = lo;
      end
      ty = fy + d;
      if ($urandom_range(1)) begin
        {fx, fy, tx, ty} = {fy, fx, ty, tx};
      end
    end
    send_pair(fx, fy, tx, ty);
  endtask

  // Axes, coincident points, extreme spans, quadrant edges and small diagonals.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // coincident points
    send_pair(0, 0, 0, 0);
    send_pair(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    // the four axes, short and full span
    send_pair(0, 0, 5, 0);
    send_pair(0, 0, -5, 0);
    send_pair(0, 0, 0, 7);
    send_pair(0, 0, 0, -7);
    send_pair(COORD_MIN, 3, COORD_MAX, 3);
    send_pair(COORD_MAX, -3, COORD_MIN, -3);
    send_pair(9, COORD_MIN, 9, COORD_MAX);
    send_pair(-9, COORD_MAX, -9, COORD_MIN);
    // full-span diagonals, one per quadrant
    send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_pair(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_pair(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    send_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    // tiny angles either side of each axis; just below a full turn is 65535
    send_pair(COORD_MIN, 0, COORD_MAX, 1);
    send_pair(COORD_MIN, 0, COORD_MAX, -1);
    send_pair(0, COORD_MIN, 1, COORD_MAX);
    send_pair(0, COORD_MIN, -1, COORD_MAX);
    send_pair(COORD_MAX, 0, COORD_MIN, 1);
    send_pair(COORD_MAX, 0, COORD_MIN, -1);
    send_pair(0, COORD_MAX, -1, COORD_MIN);
    send_pair(0, COORD_MAX, 1, COORD_MIN);
    // unit diagonals
    send_pair(0, 0, 1, 1);
    send_pair(0, 0, -1, 1);
    send_pair(0, 0, -1, -1);
    send_pair(0, 0, 1, -1);
  endtask

  task automatic test_random(input int idle_pct, input int stall_pct);
    int n;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (n = 0; n < RANDOM_ITEMS; n++) send_random_pair();
  endtask

  // Hold the output off for a long stretch while pairs keep coming, so the
  // pipeline fills and pushes back on the input.
  task automatic test_backpressure();
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (n = 0; n < 80; n++) send_random_pair();
    join
  endtask

  // Receiver: random stalls, or a solid hold-off while the pressure test asks.
  always @(posedge clk) begin
    result.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Record each accepted pair with its bearing, and check each accepted
  // bearing against the oldest one still owed.
  always @(posedge clk) begin
    bearing_exp_t owed;
    if (!rst) begin
      if (points.valid && points.ready) begin
        owed.from_x  = points.from_x;
        owed.from_y  = points.from_y;
        owed.to_x    = points.to_x;
        owed.to_y    = points.to_y;
        owed.bearing = bearing_of(points.from_x, points.from_y,
                                  points.to_x, points.to_y);
        pending_bearings = {pending_bearings, owed};
      end
      if (result.valid && result.ready) begin
        if (pending_bearings.size() == 0) begin
          $error("bearing: no pair outstanding, expected none, actual %0d",
                 result.bearing);
          mismatches++;
        end else begin
          owed = pending_bearings.pop_front();
          bearings_checked++;
          if (result.bearing !== owed.bearing) begin
            $error("bearing mismatch for (%0d,%0d)->(%0d,%0d): expected %0d, actual %0d",
                   owed.from_x, owed.from_y, owed.to_x, owed.to_y,
                   owed.bearing, result.bearing);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: give up once nothing has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (points.valid && points.ready) || (result.valid && result.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    hold_off       = 1'b0;
    points.valid   = 1'b0;
    points.from_x  = '0;
    points.from_y  = '0;
    points.to_x    = '0;
    points.to_y    = '0;
    pairs_sent     = 0;
    bearings_checked = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(0, 0);
    test_random(67, 0);
    test_random(0, 67);
    test_random(11, 11);
    test_backpressure();

    // drop valid, drain the pipeline, then watch for stray results
    points.valid   <= 1'b0;
    recv_stall_pct = 0;
    while (pending_bearings.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    $display("Sent %0d point pairs, checked %0d bearings: axes, coincident points,",
             pairs_sent, bearings_checked);
    $display("quadrant edges and random pairs under four idling mixes and a long output hold.");
    if (mismatches == 0 && pending_bearings.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
